>>> hw/rtl/grid_ray_cast_distance_defines.svh
// ----------------------------------------------------------------------------
// Grid ray cast distance assertion macros
// Shared concurrent property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CAST_DISTANCE_DEFINES_SVH
`define GRID_RAY_CAST_DISTANCE_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define GRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grid_ray_cast_distance: property violated");

// Next-cycle implication, gated by reset.
`define GRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grid_ray_cast_distance: property violated");

`endif

>>> hw/rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// Grid ray cast package
// Constants, payload types and state encodings shared by the ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int unsigned GRID_W     = 8;
  localparam int unsigned GRID_H     = 8;
  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned ANGLE_BITS = 12;
  localparam int unsigned QBITS      = ANGLE_BITS - 2;

  localparam int unsigned POS_W      = 15;
  localparam int unsigned ANG_IN_W   = 12;
  localparam int unsigned DOUT_W     = 16;
  localparam int unsigned MAP_W      = 64;
  localparam int unsigned MAP_IW     = 6;

  localparam int unsigned MAG_W      = 16;
  localparam int unsigned Z_W        = 17;
  localparam int unsigned MUL_W      = 18;
  localparam int unsigned QUO_W      = FRAC_BITS + 17;
  localparam int unsigned DIV_CW     = $clog2(QUO_W);
  localparam int unsigned BUDGET     = GRID_W * GRID_H;
  localparam int unsigned CNT_W      = $clog2(BUDGET + 1);
  localparam int unsigned DIST_W     = QUO_W + CNT_W;
  localparam int unsigned GAP_W      = FRAC_BITS + 1;
  localparam int unsigned CELL_W     = POS_W - FRAC_BITS;
  localparam int unsigned ROW_W      = CELL_W + CNT_W + 2;
  localparam int unsigned X_W        = DIST_W + 2;
  localparam int unsigned CIDX_W     = $clog2(GRID_W);
  localparam int unsigned RIDX_W     = $clog2(GRID_H);

  // Quarter-wave sine polynomial coefficients
  localparam logic [MUL_W-1:0] POLY_A = MUL_W'(9279);
  localparam logic [MUL_W-1:0] POLY_B = MUL_W'(84095);
  localparam logic [MUL_W-1:0] POLY_C = MUL_W'(205887);

  localparam logic [DOUT_W-1:0] DIST_MAX = '1;

  typedef logic [ANGLE_BITS-1:0]  angle_t;
  typedef logic [QBITS:0]         qres_t;
  typedef logic signed [ROW_W-1:0] crd_t;
  typedef logic signed [X_W-1:0]  xpos_t;

  typedef struct packed {
    logic [POS_W-1:0]    origin_x;
    logic [POS_W-1:0]    origin_y;
    logic [ANG_IN_W-1:0] angle;
  } ray_req_t;

  typedef struct packed {
    logic [DOUT_W-1:0] distance;
    logic              hit;
  } ray_rsp_t;

  typedef struct packed {
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [MAG_W-1:0]  sm;
    logic [MAG_W-1:0]  cm;
    logic              sneg;
    logic              cneg;
    logic              h_act;
    logic              v_act;
    logic [QUO_W-1:0]  step_h;
    logic [QUO_W-1:0]  step_v;
    logic [DIST_W-1:0] dist_h;
    logic [DIST_W-1:0] dist_v;
    crd_t              row_h;
    crd_t              col_v;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_TRIG,
    F_DIVGO,
    F_DIV,
    F_INIT,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_STEP
  } back_state_e;

endpackage

>>> hw/rtl/grid_ray_cast_distance.sv
// ----------------------------------------------------------------------------
// Grid ray cast distance
// Flow: front-end setup, then a B_MUL and a B_STEP state per crossing examined (at most
//   GRID_W*GRID_H+1, the last only to detect a spent budget), then the result register.
// Requests: one at a time through the front end, which takes no new one until its
//   job is queued; a long walk holds the front back via the queue.
// Reset: asynchronous, active low; clears control state and the grid map.
// ----------------------------------------------------------------------------
module grid_ray_cast_distance (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  grc_pkg::ray_req_t         in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output grc_pkg::ray_rsp_t         out_rsp_o,
  input  logic                      cfg_we_i,
  input  logic [grc_pkg::MAP_W-1:0] cfg_wdata_i
);

  // Occupancy map: bit row*GRID_W+col set marks a wall cell.
  logic [grc_pkg::MAP_W-1:0] grid_map_q;

  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  grc_pkg::job_t fq_job, qb_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_map_q <= '0;
    end else if (cfg_we_i) begin
      grid_map_q <= cfg_wdata_i;
    end
  end

  // Front end: take one request at a time, run the eight-step sine/cosine
  // polynomial on one shared multiplier, then both reciprocals in parallel,
  // then scale the gap to the first grid line in each direction.
  grc_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_req_i,
    .job_valid_o(fq_valid),
    .job_ready_i(fq_ready),
    .job_o      (fq_job)
  );

  // Decouple setup from the walk so the next request can be prepared while
  // the previous ray is still stepping.
  grc_queue u_queue (
    .clk_i,
    .rst_ni,
    .in_valid_i (fq_valid),
    .in_ready_o (fq_ready),
    .in_job_i   (fq_job),
    .out_valid_o(qb_valid),
    .out_ready_i(qb_ready),
    .out_job_o  (qb_job)
  );

  // Walker: B_MUL forms the crossing offsets, B_STEP tests the nearer
  // crossing and advances; the result sits in a register so the walker only
  // waits when a finished result is still unclaimed.
  grc_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i(qb_valid),
    .job_ready_o(qb_ready),
    .job_i      (qb_job),
    .grid_map_i (grid_map_q),
    .out_valid_o,
    .out_ready_i,
    .out_rsp_o
  );

endmodule

>>> hw/rtl/grc_div.sv
// ----------------------------------------------------------------------------
// Grid ray cast reciprocal divider
// Restoring divider, one quotient bit per cycle, of 2^(QUO_W-1) by a magnitude.
// ----------------------------------------------------------------------------
module grc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [grc_pkg::MAG_W-1:0]     divisor_i,
  output logic                          busy_o,
  output logic [grc_pkg::QUO_W-1:0]     quotient_o
);

  logic                       busy_q, busy_d;
  logic [grc_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic [grc_pkg::MAG_W-1:0]  rem_q, div_q;
  logic [grc_pkg::QUO_W-1:0]  quo_q;
  logic [grc_pkg::MAG_W:0]    shifted;
  logic                       ge;

  // The dividend has a single set bit at the top
  assign shifted = {rem_q, (cnt_q == grc_pkg::DIV_CW'(grc_pkg::QUO_W - 1))};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = grc_pkg::DIV_CW'(grc_pkg::QUO_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - grc_pkg::DIV_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? grc_pkg::MAG_W'(shifted - {1'b0, div_q}) : grc_pkg::MAG_W'(shifted);
      quo_q <= {quo_q[grc_pkg::QUO_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> hw/rtl/grc_front.sv
// ----------------------------------------------------------------------------
// Grid ray cast front end
// Take a request, evaluate sine and cosine, reciprocals and first crossings.
// ----------------------------------------------------------------------------
module grc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  grc_pkg::ray_req_t in_req_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output grc_pkg::job_t     job_o
);

  grc_pkg::front_state_e state_q, state_d;
  logic [2:0]            step_q;
  logic                  div_start;
  logic                  busy_s, busy_c;
  logic [grc_pkg::QUO_W-1:0] quo_s, quo_c;

  logic [grc_pkg::POS_W-1:0] px_q, py_q;
  logic [grc_pkg::Z_W-1:0]   zs_q, zc_q, z2s_q, z2c_q;
  logic [grc_pkg::MUL_W-1:0] ts_q, tc_q;
  logic [grc_pkg::MAG_W-1:0] sm_q, cm_q;
  logic                      sneg_q, cneg_q;
  logic [grc_pkg::DIST_W-1:0] dist_h_q, dist_v_q;

  grc_pkg::angle_t           ang_s, ang_c;
  logic [1:0]                ph;
  logic                      ch;
  logic [grc_pkg::Z_W-1:0]   z_sel, z2_sel;
  logic [grc_pkg::MUL_W-1:0] t_sel, mul_a, mul_b;
  logic [2*grc_pkg::MUL_W-1:0] prod;

  logic [grc_pkg::GAP_W-1:0] gap_h, gap_v;
  logic [grc_pkg::GAP_W+grc_pkg::QUO_W-1:0] pg_h, pg_v;
  logic [grc_pkg::CELL_W-1:0] ix, iy;

  function automatic logic [grc_pkg::Z_W-1:0] quarter_z(grc_pkg::angle_t a);
    grc_pkg::qres_t r;
    r = {1'b0, a[grc_pkg::QBITS-1:0]};
    if (a[grc_pkg::QBITS]) begin
      r = grc_pkg::qres_t'(1 << grc_pkg::QBITS) - r;
    end
    return grc_pkg::Z_W'(r) << (16 - grc_pkg::QBITS);
  endfunction

  grc_div u_div_s (
    .clk_i, .rst_ni, .start_i(div_start), .divisor_i(sm_q),
    .busy_o(busy_s), .quotient_o(quo_s)
  );

  grc_div u_div_c (
    .clk_i, .rst_ni, .start_i(div_start), .divisor_i(cm_q),
    .busy_o(busy_c), .quotient_o(quo_c)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      grc_pkg::F_IDLE:  if (in_valid_i) state_d = grc_pkg::F_TRIG;
      grc_pkg::F_TRIG:  if (step_q == 3'd7) state_d = grc_pkg::F_DIVGO;
      grc_pkg::F_DIVGO: state_d = grc_pkg::F_DIV;
      grc_pkg::F_DIV:   if (!busy_s && !busy_c) state_d = grc_pkg::F_INIT;
      grc_pkg::F_INIT:  state_d = grc_pkg::F_PUSH;
      grc_pkg::F_PUSH:  if (job_ready_i) state_d = grc_pkg::F_IDLE;
      default:          state_d = grc_pkg::F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    job_valid_o = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      grc_pkg::F_IDLE:  in_ready_o  = 1'b1;
      grc_pkg::F_DIVGO: div_start   = 1'b1;
      grc_pkg::F_PUSH:  job_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grc_pkg::F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == grc_pkg::F_IDLE) begin
        step_q <= '0;
      end else if (state_q == grc_pkg::F_TRIG) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  // Shared polynomial multiplier: phase in step[2:1], sine or cosine in step[0]
  assign ang_s  = grc_pkg::angle_t'(in_req_i.angle);
  assign ang_c  = ang_s + grc_pkg::angle_t'(1 << grc_pkg::QBITS);
  assign ph     = step_q[2:1];
  assign ch     = step_q[0];
  assign z_sel  = ch ? zc_q : zs_q;
  assign z2_sel = ch ? z2c_q : z2s_q;
  assign t_sel  = ch ? tc_q : ts_q;

  always_comb begin
    case (ph)
      2'd0: begin
        mul_a = grc_pkg::MUL_W'(z_sel);
        mul_b = grc_pkg::MUL_W'(z_sel);
      end
      2'd1: begin
        mul_a = grc_pkg::POLY_A;
        mul_b = grc_pkg::MUL_W'(z2_sel);
      end
      2'd2: begin
        mul_a = grc_pkg::POLY_B - t_sel;
        mul_b = grc_pkg::MUL_W'(z2_sel);
      end
      default: begin
        mul_a = grc_pkg::MUL_W'(z_sel);
        mul_b = grc_pkg::POLY_C - t_sel;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // First crossing gaps from the fractional part of the origin
  assign ix    = px_q[grc_pkg::POS_W-1:grc_pkg::FRAC_BITS];
  assign iy    = py_q[grc_pkg::POS_W-1:grc_pkg::FRAC_BITS];
  assign gap_h = sneg_q ? grc_pkg::GAP_W'(py_q[grc_pkg::FRAC_BITS-1:0])
                        : grc_pkg::GAP_W'(1 << grc_pkg::FRAC_BITS)
                          - grc_pkg::GAP_W'(py_q[grc_pkg::FRAC_BITS-1:0]);
  assign gap_v = cneg_q ? grc_pkg::GAP_W'(px_q[grc_pkg::FRAC_BITS-1:0])
                        : grc_pkg::GAP_W'(1 << grc_pkg::FRAC_BITS)
                          - grc_pkg::GAP_W'(px_q[grc_pkg::FRAC_BITS-1:0]);
  assign pg_h  = gap_h * quo_s;
  assign pg_v  = gap_v * quo_c;

  always_ff @(posedge clk_i) begin
    if (state_q == grc_pkg::F_IDLE && in_valid_i) begin
      px_q   <= in_req_i.origin_x;
      py_q   <= in_req_i.origin_y;
      zs_q   <= quarter_z(ang_s);
      zc_q   <= quarter_z(ang_c);
      sneg_q <= ang_s[grc_pkg::ANGLE_BITS-1];
      cneg_q <= ang_c[grc_pkg::ANGLE_BITS-1];
    end
    if (state_q == grc_pkg::F_TRIG) begin
      case (ph)
        2'd0: begin
          if (ch) z2c_q <= prod[16 +: grc_pkg::Z_W];
          else    z2s_q <= prod[16 +: grc_pkg::Z_W];
        end
        2'd1, 2'd2: begin
          if (ch) tc_q <= prod[16 +: grc_pkg::MUL_W];
          else    ts_q <= prod[16 +: grc_pkg::MUL_W];
        end
        default: begin
          if (ch) cm_q <= prod[17 +: grc_pkg::MAG_W];
          else    sm_q <= prod[17 +: grc_pkg::MAG_W];
        end
      endcase
    end
    if (state_q == grc_pkg::F_INIT) begin
      dist_h_q <= grc_pkg::DIST_W'(pg_h >> grc_pkg::FRAC_BITS);
      dist_v_q <= grc_pkg::DIST_W'(pg_v >> grc_pkg::FRAC_BITS);
    end
  end

  always_comb begin
    job_o.px     = px_q;
    job_o.py     = py_q;
    job_o.sm     = sm_q;
    job_o.cm     = cm_q;
    job_o.sneg   = sneg_q;
    job_o.cneg   = cneg_q;
    job_o.h_act  = sm_q != '0;
    job_o.v_act  = cm_q != '0;
    job_o.step_h = quo_s;
    job_o.step_v = quo_c;
    job_o.dist_h = dist_h_q;
    job_o.dist_v = dist_v_q;
    job_o.row_h  = sneg_q ? grc_pkg::crd_t'(iy) - grc_pkg::crd_t'(1)
                          : grc_pkg::crd_t'(iy) + grc_pkg::crd_t'(1);
    job_o.col_v  = cneg_q ? grc_pkg::crd_t'(ix) - grc_pkg::crd_t'(1)
                          : grc_pkg::crd_t'(ix) + grc_pkg::crd_t'(1);
  end

endmodule

>>> hw/rtl/grc_queue.sv
// ----------------------------------------------------------------------------
// Grid ray cast job queue
// Two-entry queue between the front end and the walker.
// ----------------------------------------------------------------------------
module grc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  grc_pkg::job_t in_job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output grc_pkg::job_t out_job_o
);

  grc_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_job_i;
  end

endmodule

>>> hw/rtl/grc_back.sv
// ----------------------------------------------------------------------------
// Grid ray cast walker
// Step grid-line crossings, test wall cells and hold the result.
// ----------------------------------------------------------------------------
module grc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  grc_pkg::job_t             job_i,
  input  logic [grc_pkg::MAP_W-1:0] grid_map_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output grc_pkg::ray_rsp_t         out_rsp_o
);

  grc_pkg::back_state_e state_q, state_d;
  grc_pkg::job_t        job_q;
  logic [grc_pkg::CNT_W-1:0]  n_q;
  logic [grc_pkg::DIST_W-1:0] off_h_q, off_v_q;
  logic                       out_valid_q;
  grc_pkg::ray_rsp_t          rsp_q, rsp_d;

  logic [grc_pkg::DIST_W+grc_pkg::MAG_W-1:0] pr_h, pr_v;
  grc_pkg::xpos_t x_h, y_v;
  logic           row_h_ok, col_v_ok, col_h_ok, row_v_ok, in_h, in_v;
  logic [grc_pkg::CIDX_W-1:0] col_h_idx, col_v_idx;
  logic [grc_pkg::RIDX_W-1:0] row_h_idx, row_v_idx;
  logic           wall_h, wall_v, take_h, done, slot_free, advance;
  logic [grc_pkg::DIST_W-1:0] hit_dist;

  function automatic logic [grc_pkg::DOUT_W-1:0] sat(logic [grc_pkg::DIST_W-1:0] d);
    return (d > grc_pkg::DIST_W'(grc_pkg::DIST_MAX)) ? grc_pkg::DIST_MAX
                                                      : grc_pkg::DOUT_W'(d);
  endfunction

  assign pr_h = job_q.dist_h * job_q.cm;
  assign pr_v = job_q.dist_v * job_q.sm;

  // Crossing positions along the other axis
  assign x_h = job_q.cneg ? grc_pkg::xpos_t'(job_q.px) - grc_pkg::xpos_t'(off_h_q)
                          : grc_pkg::xpos_t'(job_q.px) + grc_pkg::xpos_t'(off_h_q);
  assign y_v = job_q.sneg ? grc_pkg::xpos_t'(job_q.py) - grc_pkg::xpos_t'(off_v_q)
                          : grc_pkg::xpos_t'(job_q.py) + grc_pkg::xpos_t'(off_v_q);

  assign col_h_ok = !x_h[grc_pkg::X_W-1] &&
    (x_h[grc_pkg::X_W-1:grc_pkg::FRAC_BITS] < (grc_pkg::X_W-grc_pkg::FRAC_BITS)'(grc_pkg::GRID_W));
  assign row_v_ok = !y_v[grc_pkg::X_W-1] &&
    (y_v[grc_pkg::X_W-1:grc_pkg::FRAC_BITS] < (grc_pkg::X_W-grc_pkg::FRAC_BITS)'(grc_pkg::GRID_H));
  assign row_h_ok = !job_q.row_h[grc_pkg::ROW_W-1] &&
    (job_q.row_h[grc_pkg::ROW_W-2:0] < (grc_pkg::ROW_W-1)'(grc_pkg::GRID_H));
  assign col_v_ok = !job_q.col_v[grc_pkg::ROW_W-1] &&
    (job_q.col_v[grc_pkg::ROW_W-2:0] < (grc_pkg::ROW_W-1)'(grc_pkg::GRID_W));

  assign in_h = job_q.h_act && row_h_ok && col_h_ok;
  assign in_v = job_q.v_act && row_v_ok && col_v_ok;

  assign col_h_idx = x_h[grc_pkg::FRAC_BITS +: grc_pkg::CIDX_W];
  assign row_v_idx = y_v[grc_pkg::FRAC_BITS +: grc_pkg::RIDX_W];
  assign row_h_idx = job_q.row_h[grc_pkg::RIDX_W-1:0];
  assign col_v_idx = job_q.col_v[grc_pkg::CIDX_W-1:0];

  assign wall_h = grid_map_i[grc_pkg::MAP_IW'(row_h_idx * grc_pkg::GRID_W + col_h_idx)];
  assign wall_v = grid_map_i[grc_pkg::MAP_IW'(row_v_idx * grc_pkg::GRID_W + col_v_idx)];

  // Nearer crossing; a tie goes to the vertical one
  assign take_h = job_q.h_act && (!job_q.v_act || job_q.dist_h < job_q.dist_v);

  always_comb begin
    done     = 1'b0;
    rsp_d    = '{distance: grc_pkg::DIST_MAX, hit: 1'b0};
    hit_dist = take_h ? job_q.dist_h : job_q.dist_v;
    if (n_q == grc_pkg::CNT_W'(grc_pkg::BUDGET)) begin
      done = 1'b1;
    end else if (!in_h && !in_v) begin
      done = 1'b1;
    end else if (take_h ? (in_h && wall_h) : (in_v && wall_v)) begin
      done  = 1'b1;
      rsp_d = '{distance: sat(hit_dist), hit: 1'b1};
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign advance   = (state_q == grc_pkg::B_STEP) && !done;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      grc_pkg::B_IDLE: if (job_valid_i) state_d = grc_pkg::B_MUL;
      grc_pkg::B_MUL:  state_d = grc_pkg::B_STEP;
      grc_pkg::B_STEP: begin
        if (!done) begin
          state_d = grc_pkg::B_MUL;
        end else if (slot_free) begin
          state_d = grc_pkg::B_IDLE;
        end
      end
      default: state_d = grc_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    job_ready_o = 1'b0;
    case (state_q)
      grc_pkg::B_IDLE: job_ready_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= grc_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == grc_pkg::B_STEP && done && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == grc_pkg::B_IDLE) begin
        n_q <= '0;
      end else if (advance) begin
        n_q <= n_q + grc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == grc_pkg::B_IDLE && job_valid_i) begin
      job_q <= job_i;
    end
    if (state_q == grc_pkg::B_MUL) begin
      off_h_q <= grc_pkg::DIST_W'(pr_h >> 16);
      off_v_q <= grc_pkg::DIST_W'(pr_v >> 16);
    end
    if (advance) begin
      if (take_h) begin
        job_q.dist_h <= job_q.dist_h + grc_pkg::DIST_W'(job_q.step_h);
        job_q.row_h  <= job_q.sneg ? job_q.row_h - grc_pkg::crd_t'(1)
                                   : job_q.row_h + grc_pkg::crd_t'(1);
      end else begin
        job_q.dist_v <= job_q.dist_v + grc_pkg::DIST_W'(job_q.step_v);
        job_q.col_v  <= job_q.cneg ? job_q.col_v - grc_pkg::crd_t'(1)
                                   : job_q.col_v + grc_pkg::crd_t'(1);
      end
    end
    if (state_q == grc_pkg::B_STEP && done && slot_free) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

>>> hw/rtl/grc_checker.sv
// ----------------------------------------------------------------------------
// Grid ray cast port checker
// Port-level properties of the ray caster, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_ray_cast_distance_defines.svh"

module grc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input grc_pkg::ray_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input grc_pkg::ray_rsp_t out_rsp_o
);

  // Hold a waiting result unchanged
  `GRC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // A miss always reports the saturated distance
  `GRC_ASSERT_IMP(a_miss_dist, out_valid_o && !out_rsp_o.hit, out_rsp_o.distance == grc_pkg::DIST_MAX)

  // A taken request occupies the front end for the next cycle
  `GRC_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind grid_ray_cast_distance grc_checker u_grc_checker (.*);

>>> tb/tb_grid_ray_cast_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray cast distance testbench
// Drives ray requests through the valid/ready port under several grid maps,
// predicts or looks up distance and hit for each request and checks the responses in
// order, with random idling on both sides and a stall watchdog.
// ----------------------------------------------------------------------------
module tb_grid_ray_cast_distance;

  localparam int unsigned N_RANDOM  = 1200;
  localparam int unsigned STALL_MAX = 20000;
  localparam int unsigned SETTLE    = 300;
  localparam logic [15:0] NO_DIST   = 16'hFFFF;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  grc_pkg::ray_req_t         in_req_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  grc_pkg::ray_rsp_t         out_rsp_o;
  logic                      cfg_we_i;
  logic [grc_pkg::MAP_W-1:0] cfg_wdata_i;

  grid_ray_cast_distance DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Predictor state: our own copy of the occupancy map
  logic [63:0]       wall_map;
  grc_pkg::ray_rsp_t rsp_queue[$];
  int unsigned       mismatches;
  int unsigned       n_hits, n_misses, n_sent;
  int unsigned       idle_cycles;
  bit                calm;
  bit                timed_out;

  function automatic longint quarter_wave(longint z);
    longint z2, t;
    z2 = (z * z) >>> 16;
    t  = (9279 * z2) >>> 16;
    t  = 84095 - t;
    t  = (t * z2) >>> 16;
    t  = 205887 - t;
    return (z * t) >>> 17;
  endfunction

  function automatic void trig(input logic [11:0] a, output longint mag, output bit neg);
    logic [1:0] quad;
    longint     r;
    quad = a[11:10];
    r    = a[9:0];
    if (quad[0]) r = 1024 - r;
    mag = quarter_wave(r << 6);
    neg = quad[1];
  endfunction

  function automatic bit cell_inside(longint row, longint col);
    return row >= 0 && row < grc_pkg::GRID_H && col >= 0 && col < grc_pkg::GRID_W;
  endfunction

  function automatic bit is_wall(longint row, longint col);
    logic [5:0] b;
    b = 6'(row * grc_pkg::GRID_W + col);
    return wall_map[b];
  endfunction

  // Walk horizontal and vertical line crossings, nearer first
  function automatic grc_pkg::ray_rsp_t cast_ray(grc_pkg::ray_req_t r);
    longint px, py, sm, cm, ix, iy, gap, off, x, y;
    longint step_h, step_v, dist_h, dist_v, row_h, col_v, drow, dcol, col_h, row_v;
    bit     sneg, cneg, h_act, v_act, in_h, in_v;
    grc_pkg::ray_rsp_t res;
    px = r.origin_x; py = r.origin_y;
    ix = px >>> grc_pkg::FRAC_BITS; iy = py >>> grc_pkg::FRAC_BITS;
    step_h = 0; step_v = 0; dist_h = 0; dist_v = 0;
    row_h = 0; col_v = 0; drow = 1; dcol = 1;
    trig(r.angle, sm, sneg);
    trig(r.angle + 12'd1024, cm, cneg);
    h_act = sm != 0;
    v_act = cm != 0;
    if (h_act) begin
      step_h = (longint'(1) << 28) / sm;
      if (!sneg) begin
        gap = ((iy + 1) << grc_pkg::FRAC_BITS) - py; row_h = iy + 1; drow = 1;
      end else begin
        gap = py - (iy << grc_pkg::FRAC_BITS); row_h = iy - 1; drow = -1;
      end
      dist_h = (gap * step_h) >>> grc_pkg::FRAC_BITS;
    end
    if (v_act) begin
      step_v = (longint'(1) << 28) / cm;
      if (!cneg) begin
        gap = ((ix + 1) << grc_pkg::FRAC_BITS) - px; col_v = ix + 1; dcol = 1;
      end else begin
        gap = px - (ix << grc_pkg::FRAC_BITS); col_v = ix - 1; dcol = -1;
      end
      dist_v = (gap * step_v) >>> grc_pkg::FRAC_BITS;
    end
    for (int n = 0; n < grc_pkg::GRID_W * grc_pkg::GRID_H; n++) begin
      in_h = 0; in_v = 0;
      if (h_act) begin
        off   = (dist_h * cm) >>> 16;
        x     = cneg ? px - off : px + off;
        col_h = x < 0 ? -1 : x >>> grc_pkg::FRAC_BITS;
        in_h  = cell_inside(row_h, col_h);
      end
      if (v_act) begin
        off   = (dist_v * sm) >>> 16;
        y     = sneg ? py - off : py + off;
        row_v = y < 0 ? -1 : y >>> grc_pkg::FRAC_BITS;
        in_v  = cell_inside(row_v, col_v);
      end
      if (!in_h && !in_v) break;
      if (h_act && (!v_act || dist_h < dist_v)) begin
        if (in_h && is_wall(row_h, col_h)) begin
          res.distance = dist_h > 65535 ? NO_DIST : 16'(dist_h);
          res.hit = 1'b1;
          return res;
        end
        dist_h += step_h; row_h += drow;
      end else begin
        if (in_v && is_wall(row_v, col_v)) begin
          res.distance = dist_v > 65535 ? NO_DIST : 16'(dist_v);
          res.hit = 1'b1;
          return res;
        end
        dist_v += step_v; col_v += dcol;
      end
    end
    res.distance = NO_DIST;
    res.hit = 1'b0;
    return res;
  endfunction

  // Directed table; a typed expectation is used where has_exp is set
  typedef struct {
    logic [14:0]       ox;
    logic [14:0]       oy;
    logic [11:0]       ang;
    bit                has_exp;
    grc_pkg::ray_rsp_t exp_rsp;
  } ray_row_t;

  ray_row_t dir_rows[$];

  task automatic add_row(logic [14:0] ox, logic [14:0] oy, logic [11:0] ang,
                         bit has_exp = 0, logic [15:0] d = 0, logic h = 0);
    ray_row_t e;
    e.ox = ox; e.oy = oy; e.ang = ang; e.has_exp = has_exp;
    e.exp_rsp.distance = d; e.exp_rsp.hit = h;
    dir_rows.push_back(e);
  endtask

  // Hold valid and payload until accepted; idle before in bursts. Valid is
  // left high after acceptance so a back-to-back request replaces it in the
  // same step; drain() drops it.
  task automatic send_ray(logic [14:0] ox, logic [14:0] oy, logic [11:0] ang,
                          bit has_exp, grc_pkg::ray_rsp_t exp_rsp);
    grc_pkg::ray_req_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    r.origin_x = ox; r.origin_y = oy; r.angle = ang;
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    rsp_queue.push_back(has_exp ? exp_rsp : cast_ray(r));
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (rsp_queue.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic load_map(logic [63:0] m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    wall_map = m;
  endtask

  // Well-formed ray: origin inside the grid, any direction
  task automatic random_ray();
    logic [14:0]       ox, oy;
    grc_pkg::ray_rsp_t none;
    none = '0;
    if ($urandom_range(0, 9) == 0) begin
      ox = 15'($urandom); oy = 15'($urandom);
    end else begin
      ox = 15'($urandom_range(0, (grc_pkg::GRID_W << grc_pkg::FRAC_BITS) - 1));
      oy = 15'($urandom_range(0, (grc_pkg::GRID_H << grc_pkg::FRAC_BITS) - 1));
    end
    send_ray(ox, oy, 12'($urandom), 0, none);
  endtask

  // Response side: random stalls, compare against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (rsp_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_rsp_o);
        end else begin
          grc_pkg::ray_rsp_t e;
          e = rsp_queue.pop_front();
          if (out_rsp_o.distance !== e.distance || out_rsp_o.hit !== e.hit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: distance exp %0d got %0d, hit exp %0b got %0b",
                       e.distance, out_rsp_o.distance, e.hit, out_rsp_o.hit);
          end
          if (e.hit) n_hits++; else n_misses++;
        end
      end
      // drop ready for short bursts, never in the calm tail
      out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 4) != 0);
    end
  end

  // Watchdog: count cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_MAX) begin
      timed_out = 1;
      $display("FAIL grid_ray_cast_distance");
      $finish;
    end
  end

  initial begin
    logic [63:0]       maps[6];
    grc_pkg::ray_rsp_t none;
    none        = '0;
    mismatches  = 0; n_hits = 0; n_misses = 0; n_sent = 0;
    idle_cycles = 0; calm = 0; timed_out = 0;
    wall_map    = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty map after reset: every ray misses
    add_row(15'h0000, 15'h0000, 12'd0,    1, NO_DIST, 0);
    add_row(15'h7FFF, 15'h7FFF, 12'd4095, 1, NO_DIST, 0);
    add_row(15'h4800, 15'h2800, 12'd1024, 1, NO_DIST, 0);
    foreach (dir_rows[i])
      send_ray(dir_rows[i].ox, dir_rows[i].oy, dir_rows[i].ang,
               dir_rows[i].has_exp, dir_rows[i].exp_rsp);
    drain();

    // Walled border; axis-aligned rays, diagonals (ties), origins at the grid edges
    load_map(64'hFF81_8181_8181_81FF);
    dir_rows.delete();
    add_row(15'h3800, 15'h3800, 12'd0);
    add_row(15'h3800, 15'h3800, 12'd1024);
    add_row(15'h3800, 15'h3800, 12'd2048);
    add_row(15'h3800, 15'h3800, 12'd3072);
    add_row(15'h3000, 15'h3000, 12'd512);
    add_row(15'h3000, 15'h3000, 12'd1536);
    add_row(15'h3000, 15'h3000, 12'd2560);
    add_row(15'h3000, 15'h3000, 12'd3584);
    add_row(15'h0000, 15'h0000, 12'd0);
    add_row(15'h7FFF, 15'h7FFF, 12'd2560);
    add_row(15'h7FFF, 15'h1000, 12'd2048);
    add_row(15'h1000, 15'h7FFF, 12'd3072);
    add_row(15'h2555, 15'h4AAA, 12'd1);
    add_row(15'h2555, 15'h4AAA, 12'd1023);
    add_row(15'h2555, 15'h4AAA, 12'd4095);
    add_row(15'h5FFF, 15'h0001, 12'd2047);
    foreach (dir_rows[i])
      send_ray(dir_rows[i].ox, dir_rows[i].oy, dir_rows[i].ang, 0, none);
    drain();

    // Random phases across several maps, extremes among them
    maps[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    maps[1] = 64'h0000_0000_0000_0001;
    maps[2] = 64'h8000_0000_0000_0000;
    maps[3] = {$urandom, $urandom} & {$urandom, $urandom};
    maps[4] = {$urandom, $urandom};
    maps[5] = 64'h0;
    foreach (maps[m]) begin
      load_map(maps[m]);
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        if (m == 5 && i > N_RANDOM / 12) calm = 1;  // no idling in the tail
        random_ray();
      end
      drain();
    end

    $display("covered %0d rays over 8 grid maps: %0d hits, %0d misses",
             n_sent, n_hits, n_misses);
    if (mismatches == 0 && rsp_queue.size() == 0) begin
      $display("PASS grid_ray_cast_distance");
    end else begin
      $display("%0d mismatches, %0d responses outstanding", mismatches, rsp_queue.size());
      $display("FAIL grid_ray_cast_distance");
    end
    $finish;
  end

endmodule
